// ===== hw/rtl/uqbp_pkg.sv =====
// shared types and constants for the uniform quantiser and bit packer
package uqbp_pkg;

	// one sample in Q2.13 fixed point equals this
	localparam int QOne = 8192;

	// code_width value that selects eight levels; any other value means four
	localparam logic [1:0] CwEight = 2'd3;

	// pending bit store and its fill count
	localparam int AccW  = 10;
	localparam int HeldW = 4;

	// output queue
	localparam int QDepth = 4;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);
	// most bytes one request can produce
	localparam int MaxBytes = 2;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               final_sample;
	} in_item_t;

	typedef struct packed {
		logic [7:0] packed_byte;
		logic       last_byte;
	} out_item_t;

	// bytes produced by one request, in order
	typedef struct packed {
		logic [1:0] n;
		out_item_t  b0;
		out_item_t  b1;
	} pack_res_t;

endpackage

// ===== hw/rtl/uqbp_quant.sv =====
// nearest-level quantiser: counts the midpoints that the sample lies strictly above
module uqbp_quant (
	input  logic signed [15:0] sample,
	input  logic               eight,
	output logic [2:0]         code
);

	localparam int SW = 19;
	localparam logic signed [SW-1:0] ThrFourHi = SW'(2 * uqbp_pkg::QOne);
	localparam logic signed [SW-1:0] ThrFourLo = -SW'(2 * uqbp_pkg::QOne);

	logic signed [SW-1:0] s_ext;
	logic signed [SW-1:0] s3;
	logic signed [SW-1:0] s7;

	// scaled copies so the thirds and sevenths compare exactly
	assign s_ext = SW'(sample);
	assign s3    = (s_ext <<< 1) + s_ext;
	assign s7    = (s_ext <<< 3) - s_ext;

	// count thresholds exceeded; a tie stays on the lower code
	always_comb begin
		logic signed [SW-1:0] thr;
		code = 3'd0;
		thr  = '0;
		if (eight) begin
			for (int k = 0; k < 7; k++) begin
				thr = SW'((2 * k - 6) * uqbp_pkg::QOne);
				if (s7 > thr) begin
					code = code + 3'd1;
				end
			end
		end else begin
			if (s3 > ThrFourLo) begin
				code = code + 3'd1;
			end
			if (s_ext > SW'(0)) begin
				code = code + 3'd1;
			end
			if (s3 > ThrFourHi) begin
				code = code + 3'd1;
			end
		end
	end

endmodule

// ===== hw/rtl/uqbp_pack.sv =====
// bit accumulator: appends codes lsb first and splits off finished bytes
module uqbp_pack (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic                final_sample,
	input  logic                eight,
	input  logic [2:0]          code,
	output uqbp_pkg::pack_res_t res
);

	localparam int AccW  = uqbp_pkg::AccW;
	localparam int HeldW = uqbp_pkg::HeldW;

	logic [AccW-1:0]  acc_q;
	logic [HeldW-1:0] held_q;
	logic [AccW-1:0]  acc_d;
	logic [HeldW-1:0] held_d;
	logic [AccW:0]    merged;
	logic [HeldW-1:0] new_held;

	// append the code above the bits already held
	assign merged   = {1'b0, acc_q} | ((AccW + 1)'(code) << held_q[2:0]);
	assign new_held = held_q + (eight ? HeldW'(3) : HeldW'(2));

	// byte split and flush on the final sample
	always_comb begin
		res    = '0;
		acc_d  = merged[AccW-1:0];
		held_d = new_held;
		if (new_held >= HeldW'(8)) begin
			res.n              = 2'd1;
			res.b0.packed_byte = merged[7:0];
			res.b0.last_byte   = final_sample && (new_held == HeldW'(8));
			acc_d              = {8'b0, merged[AccW-1:8]};
			held_d             = new_held - HeldW'(8);
			if (final_sample && (held_d != '0)) begin
				res.n              = 2'd2;
				res.b1.packed_byte = acc_d[7:0];
				res.b1.last_byte   = 1'b1;
			end
		end else if (final_sample) begin
			res.n              = 2'd1;
			res.b0.packed_byte = merged[7:0];
			res.b0.last_byte   = 1'b1;
		end
		if (final_sample) begin
			acc_d  = '0;
			held_d = '0;
		end
		if (!fire) begin
			res.n = 2'd0;
		end
	end

	// accumulator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			held_q <= '0;
		end else if (fire) begin
			acc_q  <= acc_d;
			held_q <= held_d;
		end
	end

	// between requests fewer than a byte is pending
	a_held_below_byte: assert property (@(posedge clk) disable iff (!arst_n)
		held_q < HeldW'(8))
		else $error("pending bit count reached a full byte");

	// a final sample empties the accumulator
	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && final_sample |=> (held_q == '0) && (acc_q == '0))
		else $error("accumulator not cleared after final sample");

	// bits above the held count stay zero
	a_acc_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_q >> held_q) == '0)
		else $error("stale bits above pending count");

endmodule

// ===== hw/rtl/uqbp_outq.sv =====
// output queue: up to two bytes in a cycle, one out unless stalled
module uqbp_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  uqbp_pkg::pack_res_t res,
	output logic                room,
	output logic                out_valid,
	input  logic                out_stall,
	output uqbp_pkg::out_item_t out_data
);

	localparam int QDepth = uqbp_pkg::QDepth;
	localparam int QPtrW  = uqbp_pkg::QPtrW;
	localparam int QCntW  = uqbp_pkg::QCntW;

	uqbp_pkg::out_item_t mem_q [QDepth];
	logic [QPtrW-1:0]    wr_q;
	logic [QPtrW-1:0]    rd_q;
	logic [QCntW-1:0]    count_q;
	logic                pop;

	// space for the largest burst one request can make
	assign room      = count_q <= QCntW'(QDepth - uqbp_pkg::MaxBytes);
	assign out_valid = count_q != '0;
	assign out_data  = mem_q[rd_q];
	assign pop       = out_valid && !out_stall;

	// byte storage
	always_ff @(posedge clk) begin
		if (res.n != 2'd0) begin
			mem_q[wr_q] <= res.b0;
		end
		if (res.n == 2'd2) begin
			mem_q[wr_q + QPtrW'(1)] <= res.b1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + QPtrW'(res.n);
			rd_q    <= rd_q + QPtrW'(pop);
			count_q <= count_q + QCntW'(res.n) - QCntW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCntW'(QDepth))
		else $error("output queue overflow");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		(res.n != 2'd0) |-> room)
		else $error("bytes pushed without room");

	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		pop && (res.n == 2'd0) |=> count_q == $past(count_q) - QCntW'(1))
		else $error("fill count wrong after pop");

endmodule

// ===== hw/rtl/uniform_quantize_bit_pack.sv =====
// top level: input register, quantiser, bit packer and output queue
//
//  port group      direction  handshake          payload
//  in_*            sink       in_valid/in_stall  in_item_t  (sample, final_sample)
//  out_*           source     out_valid/out_stall out_item_t (packed_byte, last_byte)
//  cfg_*           sink       cfg_wr_en          code_width (2 bits)
//
// One request is accepted per cycle while in_stall is low; it is quantised and packed
// from the input register once the queue has room. A final sample can give two bytes;
// the four-entry output queue drains one per cycle while out_stall is low.
// in_stall rises only while the input register is full and the queue holds more than two.
// arst_n clears the control state and sets code_width to 2.
module uniform_quantize_bit_pack (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  uqbp_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output uqbp_pkg::out_item_t out_data,
	input  logic                cfg_wr_en,
	input  logic [1:0]          cfg_wr_data
);

	logic                valid_s1;
	uqbp_pkg::in_item_t  item_s1;
	logic [1:0]          code_width_q;
	logic                eight;
	logic [2:0]          code;
	logic                room;
	logic                fire;
	uqbp_pkg::pack_res_t res;

	assign eight    = code_width_q == uqbp_pkg::CwEight;
	assign fire     = valid_s1 && room;
	assign in_stall = valid_s1 && !room;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_width_q <= 2'd2;
		end else if (cfg_wr_en) begin
			code_width_q <= cfg_wr_data;
		end
	end

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	uqbp_quant u_quant (
		.sample (item_s1.sample),
		.eight  (eight),
		.code   (code)
	);

	uqbp_pack u_pack (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.final_sample (item_s1.final_sample),
		.eight        (eight),
		.code         (code),
		.res          (res)
	);

	uqbp_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// a request held in the input register is consumed as soon as there is room
	a_fire_on_room: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && room |=> !($past(in_stall)))
		else $error("input held despite queue room");

	// a final sample always produces at least one byte
	a_final_emits: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item_s1.final_sample |-> res.n != 2'd0)
		else $error("final sample produced no byte");

	// the last flag only sits on the final byte of a burst
	a_last_on_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(res.n == 2'd2) |-> !res.b0.last_byte && res.b1.last_byte)
		else $error("last flag on wrong byte");

endmodule

// ===== bench/uqbp_checker.sv =====
// checker for the quantiser and bit packer: predicts packed bytes and compares the result channel
`timescale 1ns / 1ps
module uqbp_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  uqbp_pkg::in_item_t  in_data,
	input  logic                out_valid,
	input  logic                out_stall,
	input  uqbp_pkg::out_item_t out_data,
	input  logic                cfg_wr_en,
	input  logic [1:0]          cfg_wr_data,
	output int                  mismatches,
	output int                  bytes_outstanding
);

	localparam logic [1:0] CwAtReset = 2'd2;

	// predicted packer state and width setting
	logic [uqbp_pkg::AccW-1:0]  pend_bits;
	logic [uqbp_pkg::HeldW-1:0] pend_cnt;
	logic [1:0]                 width_sel;
	uqbp_pkg::out_item_t        expected_bytes[$];
	int                         results_seen;

	// level index: how many midpoints the sample lies strictly above (ties go low)
	function automatic logic [2:0] quantise(logic signed [15:0] s, logic eight);
		int         v;
		logic [2:0] code;
		v = s;
		code = '0;
		if (eight) begin
			for (int k = 0; k < 7; k++) begin
				if (7 * v > (2 * k - 6) * uqbp_pkg::QOne)
					code++;
			end
		end else begin
			if (3 * v > -2 * uqbp_pkg::QOne)
				code++;
			if (v > 0)
				code++;
			if (3 * v > 2 * uqbp_pkg::QOne)
				code++;
		end
		return code;
	endfunction

	// append one code lsb first and queue every byte it completes or flushes
	task automatic pack_request(uqbp_pkg::in_item_t req);
		logic                       eight;
		logic [uqbp_pkg::AccW-1:0]  code_bits;
		logic [uqbp_pkg::HeldW-1:0] fill;
		uqbp_pkg::out_item_t        b;
		eight = (width_sel == uqbp_pkg::CwEight);
		code_bits = uqbp_pkg::AccW'(quantise(req.sample, eight));
		pend_bits = pend_bits | (code_bits << pend_cnt[2:0]);
		fill = pend_cnt + (eight ? uqbp_pkg::HeldW'(3) : uqbp_pkg::HeldW'(2));
		if (fill >= uqbp_pkg::HeldW'(8)) begin
			b.packed_byte = pend_bits[7:0];
			b.last_byte = req.final_sample && (fill == uqbp_pkg::HeldW'(8));
			expected_bytes.push_back(b);
			pend_bits = pend_bits >> 8;
			fill = fill - uqbp_pkg::HeldW'(8);
		end
		// zero-padded partial byte on the final sample
		if (req.final_sample && fill != '0) begin
			b.packed_byte = pend_bits[7:0];
			b.last_byte = 1'b1;
			expected_bytes.push_back(b);
		end
		if (req.final_sample) begin
			pend_bits = '0;
			fill = '0;
		end
		pend_cnt = fill;
	endtask

	task automatic report_mismatch(string msg);
		mismatches++;
		$display("%0t uqbp_checker: %s", $time, msg);
	endtask

	// watch the three channels at each rising edge
	always @(posedge clk or negedge arst_n) begin
		uqbp_pkg::out_item_t want;
		if (!arst_n) begin
			pend_bits = '0;
			pend_cnt = '0;
			width_sel = CwAtReset;
			expected_bytes.delete();
			results_seen = 0;
			mismatches = 0;
			bytes_outstanding <= 0;
		end else begin
			// result side first, so a byte can never match a request taken at the same edge
			if (out_valid && !out_stall) begin
				if (expected_bytes.size() == 0) begin
					report_mismatch($sformatf("byte %0d: unexpected 0x%02h last %0b",
						results_seen, out_data.packed_byte, out_data.last_byte));
				end else begin
					want = expected_bytes.pop_front();
					if (out_data.packed_byte !== want.packed_byte)
						report_mismatch($sformatf("byte %0d: packed_byte 0x%02h, expected 0x%02h",
							results_seen, out_data.packed_byte, want.packed_byte));
					if (out_data.last_byte !== want.last_byte)
						report_mismatch($sformatf("byte %0d: last_byte %0b, expected %0b",
							results_seen, out_data.last_byte, want.last_byte));
				end
				results_seen++;
			end
			if (in_valid && !in_stall)
				pack_request(in_data);
			if (cfg_wr_en)
				width_sel = cfg_wr_data;
			bytes_outstanding <= expected_bytes.size();
		end
	end

endmodule

// ===== bench/uniform_quantize_bit_pack_tb.sv =====
// testbench top for the quantiser and bit packer: clock, reset, stimulus, stalls and verdict
`timescale 1ns / 1ps
module uniform_quantize_bit_pack_tb;

	localparam logic [1:0] CwFour        = 2'd2;
	localparam int         IdlePct       = 27;
	localparam int         HoldOffCycles = 60;
	localparam int         SettleCycles  = 8;
	localparam int         DrainLimit    = 20000;
	localparam int         PhaseItems    = 250;
	localparam int         RandomPhases  = 6;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	uqbp_pkg::in_item_t  in_data;
	logic                out_valid;
	logic                out_stall;
	uqbp_pkg::out_item_t out_data;
	logic                cfg_wr_en;
	logic [1:0]          cfg_wr_data;
	int                  mismatches;
	int                  bytes_outstanding;
	logic                quiet;
	logic                hold_off_req;

	uniform_quantize_bit_pack u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	uqbp_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.in_data          (in_data),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.out_data         (out_data),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.mismatches       (mismatches),
		.bytes_outstanding(bytes_outstanding)
	);

	// 100 MHz clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// hard stop well beyond the slowest correct run
	initial begin
		#5_000_000;
		$display("[uniform_quantize_bit_pack] ERROR");
		$finish;
	end

	// result side: random stalls, plus one long hold-off when asked
	initial begin : result_side
		bit held_off;
		held_off = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req && !held_off) begin
				held_off = 1'b1;
				out_stall <= 1'b1;
				repeat (HoldOffCycles) @(posedge clk);
			end
			out_stall <= !quiet && ($urandom_range(99) < IdlePct);
		end
	end

	// sample mix: full range, close to decision points, extremes, inside [-1,1]
	function automatic logic signed [15:0] pick_sample(logic [1:0] cw);
		int roll;
		int k;
		int t;
		int off;
		roll = $urandom_range(99);
		if (roll < 35)
			return 16'($urandom);
		if (roll < 62) begin
			if (cw == uqbp_pkg::CwEight) begin
				k = $urandom_range(6);
				t = (2 * k - 6) * uqbp_pkg::QOne / 7;
			end else begin
				k = $urandom_range(2);
				t = (2 * k - 2) * uqbp_pkg::QOne / 3;
			end
			off = $urandom_range(6);
			return 16'(t + off - 3);
		end
		if (roll < 72) begin
			case ($urandom_range(4))
				0: return 16'sh8000;
				1: return 16'sh7FFF;
				2: return 16'(uqbp_pkg::QOne);
				3: return 16'(-uqbp_pkg::QOne);
				default: return '0;
			endcase
		end
		t = $urandom_range(2 * uqbp_pkg::QOne);
		return 16'(t - uqbp_pkg::QOne);
	endfunction

	// offer one request, holding it until taken
	task automatic send_sample(logic signed [15:0] s, logic fin);
		uqbp_pkg::in_item_t req;
		while (!quiet && $urandom_range(99) < IdlePct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		req.sample = s;
		req.final_sample = fin;
		in_valid <= 1'b1;
		in_data <= req;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// stop sending until every predicted byte is out, then let the pipe empty
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (bytes_outstanding != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_width(logic [1:0] w);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= w;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// request side and verdict
	initial begin : request_side
		logic [1:0] width_now;
		logic       fin;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= CwFour;
		quiet <= 1'b0;
		hold_off_req <= 1'b0;
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// four levels from reset: extremes, zero tie, full-byte and partial flush
		send_sample(-32768, 1'b0);
		send_sample(32767, 1'b0);
		send_sample(0, 1'b0);
		send_sample(1, 1'b1);
		send_sample(-1, 1'b1);
		send_sample(8192, 1'b0);
		send_sample(-8192, 1'b0);
		send_sample(5461, 1'b0);
		send_sample(5462, 1'b0);
		send_sample(-5461, 1'b0);
		send_sample(-5462, 1'b0);
		send_sample(0, 1'b1);

		// eight levels: outer decision points, final sample giving two bytes
		wait_drained();
		write_width(uqbp_pkg::CwEight);
		send_sample(-7021, 1'b0);
		send_sample(-7022, 1'b0);
		send_sample(7022, 1'b0);
		send_sample(7021, 1'b0);
		send_sample(2341, 1'b0);
		send_sample(2340, 1'b1);
		send_sample(-32768, 1'b0);
		send_sample(32767, 1'b0);
		send_sample(0, 1'b1);

		// random phases; widths alternate and change with bits still held
		for (int p = 0; p < RandomPhases; p++) begin
			wait_drained();
			width_now = (p % 2 == 0) ? CwFour : uqbp_pkg::CwEight;
			write_width(width_now);
			quiet <= (p == 1);
			for (int i = 0; i < PhaseItems; i++) begin
				if (p == 2 && i == 30)
					hold_off_req <= 1'b1;
				if (p == 3 && i == PhaseItems / 2)
					wait_drained();
				fin = ($urandom_range(9) == 0);
				send_sample(pick_sample(width_now), fin);
			end
		end

		// final drain, bounded
		in_valid <= 1'b0;
		@(posedge clk);
		for (int n = 0; n < DrainLimit && bytes_outstanding != 0; n++)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
		@(negedge clk);
		if (mismatches == 0 && bytes_outstanding == 0)
			$display("[uniform_quantize_bit_pack] OK");
		else
			$display("[uniform_quantize_bit_pack] ERROR");
		$finish;
	end

endmodule
